// ===== rtl/u8dv_pkg.sv =====
package u8dv_pkg;

   // fixed field widths
   localparam int BYTE_W  = 8;
   localparam int CP_W    = 21;
   localparam int CODE_W  = 3;
   localparam int CHAR_W  = 32;

   // width of the saturating character counter, 8 to 32
   localparam int COUNT_BITS = 32;

   localparam logic [CP_W-1:0] CP_MAX       = CP_W'(32'h10FFFF);
   localparam logic [CP_W-1:0] SURR_LO      = CP_W'(32'hD800);
   localparam logic [CP_W-1:0] SURR_HI      = CP_W'(32'hDFFF);
   localparam logic [CP_W-1:0] MIN_TWO      = CP_W'(32'h80);
   localparam logic [CP_W-1:0] MIN_THREE    = CP_W'(32'h800);
   localparam logic [CP_W-1:0] MIN_FOUR     = CP_W'(32'h10000);
   localparam logic [BYTE_W-1:0] LEAD_LIMIT = 8'hF8;

   typedef enum logic [CODE_W-1:0] {
      ERR_NONE     = 3'd0,
      ERR_LEAD     = 3'd1,
      ERR_CONT     = 3'd2,
      ERR_OVERLONG = 3'd3,
      ERR_RANGE    = 3'd4,
      ERR_TRUNC    = 3'd5
   } err_code_type;

   typedef struct packed {
      logic [1:0]            bytes_remaining;
      logic [2:0]            sequence_length;
      logic [CP_W-1:0]       value_acc;
      logic                  error_seen;
      logic [COUNT_BITS-1:0] char_cnt;
   } state_type;

   typedef struct packed {
      logic [CP_W-1:0]   code_point;
      logic              char_done;
      logic              error_flag;
      err_code_type      error_code;
      logic              end_of_string;
      logic              string_valid;
      logic [CHAR_W-1:0] char_count;
   } result_type;

   // sequence length from the lead byte's top nibble, 0 for a bad lead
   function automatic logic [2:0] lead_len(input logic [3:0] nibble);
      logic [2:0] len;
      unique case (nibble)
         4'h0, 4'h1, 4'h2, 4'h3,
         4'h4, 4'h5, 4'h6, 4'h7: len = 3'd1;
         4'hC, 4'hD:             len = 3'd2;
         4'hE:                   len = 3'd3;
         4'hF:                   len = 3'd4;
         default:                len = 3'd0;
      endcase
      return len;
   endfunction

endpackage

// ===== rtl/u8dv_req_if.sv =====
interface u8dv_req_if;
   import u8dv_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              last_byte;

   modport source(output valid, output data_byte, output last_byte, input ready);
   modport sink(input valid, input data_byte, input last_byte, output ready);

endinterface

// ===== rtl/u8dv_rsp_if.sv =====
interface u8dv_rsp_if;
   import u8dv_pkg::*;

   logic              valid;
   logic              ready;
   logic [CP_W-1:0]   code_point;
   logic              char_done;
   logic              error_flag;
   logic [CODE_W-1:0] error_code;
   logic              end_of_string;
   logic              string_valid;
   logic [CHAR_W-1:0] char_count;

   modport source(output valid, output code_point, output char_done, output error_flag,
                  output error_code, output end_of_string, output string_valid,
                  output char_count, input ready);
   modport sink(input valid, input code_point, input char_done, input error_flag,
                input error_code, input end_of_string, input string_valid,
                input char_count, output ready);

endinterface

// ===== rtl/utf8_stream_decoder_validator_core.sv =====
// UTF-8 stream decoder and validator. Bytes of a string arrive one per request on req_ch,
// with last_byte set on the final byte. Every byte that completes a character, reports
// the string's first error, or ends the string gives one response on rsp_ch; other bytes
// give none. After the first error the rest of the string is ignored, and the final
// response carries string_valid and the saturating char_count. Throughput is one byte
// per clock; a byte waits in the input register, and the decode step's result is held in
// the response register, which drives rsp_ch. The decode step reads and
// writes the per-string state in the same cycle, which sets the one-byte-per-cycle rate.
// Backpressure on rsp_ch stalls the input only when a byte would produce a response.
module utf8_stream_decoder_validator_core (
   input logic         clock,
   input logic         reset,
   u8dv_req_if.sink    req_ch,
   u8dv_rsp_if.source  rsp_ch
);
   import u8dv_pkg::*;

   // input register
   logic              in_valid_ff;
   logic              in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;

   // per-string decode state
   state_type         state_ff;
   state_type         state_in;

   // response register
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   result_type        rsp_data_ff;

   // decode step outputs
   state_type         step_state;
   result_type        step_result;
   logic              step_produce;

   logic              out_free;
   logic              step_fire;
   logic              req_take;

   u8dv_step u_step (
      .cur_state (state_ff),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .nxt_state (step_state),
      .result    (step_result),
      .produce   (step_produce)
   );

   // response slot is free when empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   // a byte with no response never waits on the output side
   assign step_fire = in_valid_ff && (out_free || !step_produce);
   assign req_take  = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !in_valid_ff || step_fire;

   always_comb begin
      in_valid_in  = in_valid_ff;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (step_fire) begin
         in_valid_in = 1'b0;
         state_in    = step_state;
         if (step_produce) begin
            rsp_valid_in = 1'b1;
         end
      end
      if (req_take) begin
         in_valid_in = 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_ch.data_byte;
         in_last_ff <= req_ch.last_byte;
      end
      if (step_fire && step_produce) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.code_point    = rsp_data_ff.code_point;
   assign rsp_ch.char_done     = rsp_data_ff.char_done;
   assign rsp_ch.error_flag    = rsp_data_ff.error_flag;
   assign rsp_ch.error_code    = rsp_data_ff.error_code;
   assign rsp_ch.end_of_string = rsp_data_ff.end_of_string;
   assign rsp_ch.string_valid  = rsp_data_ff.string_valid;
   assign rsp_ch.char_count    = rsp_data_ff.char_count;

endmodule

// ===== rtl/u8dv_step.sv =====
module u8dv_step (
   input  u8dv_pkg::state_type          cur_state,
   input  logic [u8dv_pkg::BYTE_W-1:0]  data_byte,
   input  logic                         last_byte,
   output u8dv_pkg::state_type          nxt_state,
   output u8dv_pkg::result_type         result,
   output logic                         produce
);
   import u8dv_pkg::*;

   state_type          st;
   err_code_type       err;
   logic               done;
   logic [CP_W-1:0]    cp;
   logic [2:0]         len;
   logic [CP_W-1:0]    acc_shift;
   logic [CP_W-1:0]    min_val;
   logic [1:0]         remain_dec;

   always_comb begin
      st         = cur_state;
      err        = ERR_NONE;
      done       = 1'b0;
      cp         = '0;
      len        = lead_len(data_byte[7:4]);
      acc_shift  = {cur_state.value_acc[CP_W-7:0], data_byte[5:0]};
      remain_dec = cur_state.bytes_remaining - 2'd1;
      unique case (cur_state.sequence_length)
         3'd2:    min_val = MIN_TWO;
         3'd3:    min_val = MIN_THREE;
         default: min_val = MIN_FOUR;
      endcase

      if (!cur_state.error_seen) begin
         if (cur_state.bytes_remaining == 2'd0) begin
            if (data_byte >= LEAD_LIMIT) begin
               len = 3'd0;
            end
            unique case (len)
               3'd0: err = ERR_LEAD;
               3'd1: begin
                  cp   = CP_W'(data_byte);
                  done = 1'b1;
               end
               default: begin
                  st.sequence_length = len;
                  st.bytes_remaining = 2'(len - 3'd1);
                  unique case (len)
                     3'd2:    st.value_acc = CP_W'(data_byte[4:0]);
                     3'd3:    st.value_acc = CP_W'(data_byte[3:0]);
                     default: st.value_acc = CP_W'(data_byte[2:0]);
                  endcase
               end
            endcase
         end else if (data_byte[7:6] != 2'b10) begin
            err = ERR_CONT;
         end else begin
            st.value_acc       = acc_shift;
            st.bytes_remaining = remain_dec;
            if (remain_dec == 2'd0) begin
               // sequence complete: range checks on the finished value
               if (acc_shift < min_val) begin
                  err = ERR_OVERLONG;
               end else if (acc_shift > CP_MAX ||
                            (acc_shift >= SURR_LO && acc_shift <= SURR_HI)) begin
                  err = ERR_RANGE;
               end else begin
                  cp   = acc_shift;
                  done = 1'b1;
               end
               st.sequence_length = 3'd0;
               st.value_acc       = '0;
            end
         end

         if (err == ERR_NONE && last_byte && st.bytes_remaining != 2'd0) begin
            err = ERR_TRUNC;
         end
         if (err != ERR_NONE) begin
            st.error_seen      = 1'b1;
            done               = 1'b0;
            cp                 = '0;
            st.bytes_remaining = 2'd0;
            st.sequence_length = 3'd0;
            st.value_acc       = '0;
         end
         if (done && st.char_cnt != {COUNT_BITS{1'b1}}) begin
            st.char_cnt = st.char_cnt + COUNT_BITS'(1);
         end
      end

      produce              = done || err != ERR_NONE || last_byte;
      result.code_point    = cp;
      result.char_done     = done;
      result.error_flag    = err != ERR_NONE;
      result.error_code    = err;
      result.end_of_string = last_byte;
      result.string_valid  = last_byte && !st.error_seen;
      result.char_count    = CHAR_W'(st.char_cnt);

      // end of string: per-string state starts over
      nxt_state = last_byte ? '0 : st;
   end

endmodule

// ===== tb/utf8_stream_decoder_validator_core_test.sv =====
`timescale 1ns / 100ps

module utf8_stream_decoder_validator_core_test;
   import u8dv_pkg::*;

   // one byte of a string as the driver presents it
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } str_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   u8dv_req_if req_ch ();
   u8dv_rsp_if rsp_ch ();

   utf8_stream_decoder_validator_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // bytes waiting to be driven, and decoder responses still owed by the block
   str_byte_type byte_q[$];
   result_type   decoded_q[$];
   logic [BYTE_W-1:0] str_bytes[$];

   // percent of cycles in which each side holds off
   int tx_idle_pct;
   int rx_idle_pct;

   // shadow of the per-string decode state
   logic [1:0]            cont_left;
   logic [2:0]            seq_len;
   logic [CP_W-1:0]       acc;
   logic                  err_seen;
   logic [COUNT_BITS-1:0] n_chars;

   // run statistics
   int mismatches;
   int bytes_queued;
   int bytes_sent;
   int strings_sent;
   int rsps_seen;
   int chars_seen;
   int err_hits[6];
   int stall_cycles;

   // ------------------------------------------------------------------
   // decode one accepted byte and queue the response it should cause
   // ------------------------------------------------------------------
   function automatic void utf8_step(input logic [BYTE_W-1:0] b, input logic last);
      logic [2:0]      len;
      logic [CP_W-1:0] cp;
      logic [CP_W-1:0] floor_cp;
      logic            done;
      err_code_type    err;
      result_type      r;
      cp   = '0;
      done = 1'b0;
      err  = ERR_NONE;
      // once a string has failed, nothing else is decoded until its end
      if (!err_seen) begin
         if (cont_left == 2'd0) begin
            // lead byte: length from the top nibble
            case (b[7:4])
               4'hC, 4'hD: len = 3'd2;
               4'hE:       len = 3'd3;
               4'hF:       len = 3'd4;
               default:    len = b[7] ? 3'd0 : 3'd1;
            endcase
            // f8 and up are never legal leads
            if (b >= LEAD_LIMIT) len = 3'd0;
            if (len == 3'd0) begin
               err = ERR_LEAD;
            end else if (len == 3'd1) begin
               cp   = CP_W'(b);
               done = 1'b1;
            end else begin
               seq_len   = len;
               cont_left = 2'(len - 3'd1);
               case (len)
                  3'd2:    acc = CP_W'(b[4:0]);
                  3'd3:    acc = CP_W'(b[3:0]);
                  default: acc = CP_W'(b[2:0]);
               endcase
            end
         end else if (b[7:6] != 2'b10) begin
            err = ERR_CONT;
         end else begin
            // continuation: shift in six payload bits
            acc       = {acc[CP_W-7:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0) begin
               case (seq_len)
                  3'd2:    floor_cp = MIN_TWO;
                  3'd3:    floor_cp = MIN_THREE;
                  default: floor_cp = MIN_FOUR;
               endcase
               if (acc < floor_cp) begin
                  err = ERR_OVERLONG;
               end else if (acc > CP_MAX || (acc >= SURR_LO && acc <= SURR_HI)) begin
                  err = ERR_RANGE;
               end else begin
                  cp   = acc;
                  done = 1'b1;
               end
               seq_len = '0;
               acc     = '0;
            end
         end
         // string ends inside a sequence
         if (err == ERR_NONE && last && cont_left != 2'd0) err = ERR_TRUNC;
         if (err != ERR_NONE) begin
            err_seen  = 1'b1;
            done      = 1'b0;
            cp        = '0;
            cont_left = '0;
            seq_len   = '0;
            acc       = '0;
         end
         if (done && n_chars != {COUNT_BITS{1'b1}}) n_chars = n_chars + COUNT_BITS'(1);
      end

      // a response only for a character, a first error or the final byte
      if (done || err != ERR_NONE || last) begin
         r.code_point    = cp;
         r.char_done     = done;
         r.error_flag    = (err != ERR_NONE);
         r.error_code    = err;
         r.end_of_string = last;
         r.string_valid  = last && !err_seen;
         r.char_count    = CHAR_W'(n_chars);
         decoded_q.push_back(r);
      end

      // next string starts clean
      if (last) begin
         cont_left = '0;
         seq_len   = '0;
         acc       = '0;
         err_seen  = 1'b0;
         n_chars   = '0;
      end
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   // append the first keep bytes of a len-byte encoding of cp
   function automatic void push_seq(input logic [CP_W-1:0] cp, input int len, input int keep);
      logic [BYTE_W-1:0] enc[4];
      case (len)
         1: enc[0] = {1'b0, cp[6:0]};
         2: begin
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
         end
         3: begin
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
         end
         default: begin
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]};
            enc[3] = {2'b10, cp[5:0]};
         end
      endcase
      for (int i = 0; i < keep; i++) str_bytes.push_back(enc[i]);
   endfunction

   // legal scalar value that needs exactly len bytes
   function automatic logic [CP_W-1:0] legal_cp(input int len);
      logic [CP_W-1:0] v;
      case (len)
         1: v = CP_W'($urandom_range(32'h7F, 32'h0));
         2: v = CP_W'($urandom_range(32'h7FF, 32'h80));
         3: begin
            v = CP_W'($urandom_range(32'hFFFF, 32'h800));
            // move surrogates out of the way
            if (v >= SURR_LO && v <= SURR_HI) v = v ^ CP_W'(32'h4000);
         end
         default: v = CP_W'($urandom_range(32'h10FFFF, 32'h10000));
      endcase
      return v;
   endfunction

   // hand the assembled string to the driver, last flag on the final byte
   function automatic void queue_string();
      str_byte_type sb;
      for (int i = 0; i < str_bytes.size(); i++) begin
         sb.data = str_bytes[i];
         sb.last = (i == str_bytes.size() - 1);
         byte_q.push_back(sb);
      end
      bytes_queued += str_bytes.size();
      str_bytes.delete();
   endfunction

   // append some well-formed characters
   function automatic void push_chars(input int count);
      int len;
      for (int i = 0; i < count; i++) begin
         len = $urandom_range(4, 1);
         push_seq(legal_cp(len), len, len);
      end
   endfunction

   // one random string: mostly well formed, some with a fault, some pure noise
   function automatic void random_string();
      int              len;
      int              fault;
      logic [BYTE_W-1:0] bad;
      logic [CP_W-1:0] cp;
      if ($urandom_range(99) < 8) begin
         // raw noise
         repeat ($urandom_range(6, 1)) str_bytes.push_back(BYTE_W'($urandom));
      end else begin
         push_chars($urandom_range(8, 1));
         if ($urandom_range(99) < 35) begin
            fault = $urandom_range(5, 0);
            len   = $urandom_range(4, 2);
            case (fault)
               0: begin
                  // overlong: value that fits a shorter form
                  case (len)
                     2:       cp = CP_W'($urandom_range(32'h7F, 32'h0));
                     3:       cp = CP_W'($urandom_range(32'h7FF, 32'h0));
                     default: cp = CP_W'($urandom_range(32'hFFFF, 32'h0));
                  endcase
                  push_seq(cp, len, len);
               end
               1: push_seq(CP_W'($urandom_range(32'hDFFF, 32'hD800)), 3, 3);
               2: push_seq(CP_W'($urandom_range(32'h1FFFFF, 32'h110000)), 4, 4);
               3: begin
                  // continuation byte or f8-ff where a lead belongs
                  if ($urandom_range(1))
                     bad = BYTE_W'($urandom_range(32'hBF, 32'h80));
                  else
                     bad = BYTE_W'($urandom_range(32'hFF, 32'hF8));
                  str_bytes.push_back(bad);
               end
               4: begin
                  // sequence broken by a byte that is not 10xxxxxx
                  push_seq(legal_cp(len), len, $urandom_range(len - 1, 1));
                  bad = BYTE_W'($urandom);
                  case ($urandom_range(2))
                     0:       bad[7:6] = 2'b00;
                     1:       bad[7:6] = 2'b01;
                     default: bad[7:6] = 2'b11;
                  endcase
                  str_bytes.push_back(bad);
               end
               default: begin
                  // string stops mid-sequence
                  push_seq(legal_cp(len), len, $urandom_range(len - 1, 1));
                  fault = -1;
               end
            endcase
            // bytes after the error are ignored by the block
            if (fault >= 0 && $urandom_range(1)) begin
               if ($urandom_range(1))
                  push_chars($urandom_range(3, 1));
               else
                  repeat ($urandom_range(4, 1)) str_bytes.push_back(BYTE_W'($urandom));
            end
         end
      end
      queue_string();
   endfunction

   // queue random strings until about n_bytes more bytes are waiting
   task automatic random_strings(input int n_bytes);
      int goal;
      goal = bytes_queued + n_bytes;
      while (bytes_queued < goal) random_string();
   endtask

   // wait until every byte is in and every response is out
   task automatic drain();
      while (byte_q.size() != 0 || req_ch.valid) @(posedge clock);
      while (decoded_q.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // driver: one byte per request, random hold-off between bytes
   // ------------------------------------------------------------------
   always @(posedge clock) begin : drive_bytes
      str_byte_type sb;
      if (reset) begin
         req_ch.valid     <= 1'b0;
         req_ch.data_byte <= '0;
         req_ch.last_byte <= 1'b0;
      end else begin
         // byte taken at this edge: predict its response
         if (req_ch.valid && req_ch.ready) begin
            utf8_step(req_ch.data_byte, req_ch.last_byte);
            bytes_sent++;
            if (req_ch.last_byte) strings_sent++;
         end
         // free to present the next byte
         if (!req_ch.valid || req_ch.ready) begin
            if (byte_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
               sb = byte_q.pop_front();
               req_ch.valid     <= 1'b1;
               req_ch.data_byte <= sb.data;
               req_ch.last_byte <= sb.last;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // response side backpressure
   always @(posedge clock) begin
      if (reset)
         rsp_ch.ready <= 1'b0;
      else
         rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // ------------------------------------------------------------------
   // monitor: compare each response with the oldest prediction
   // ------------------------------------------------------------------
   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 40)
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch_results
      result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsps_seen++;
         if (decoded_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 40)
               $display("%0t ns: unexpected response, expected none, got code_point 0x%0h",
                        $time, rsp_ch.code_point);
         end else begin
            want = decoded_q.pop_front();
            check_field("code_point",    32'(want.code_point),    32'(rsp_ch.code_point));
            check_field("char_done",     32'(want.char_done),     32'(rsp_ch.char_done));
            check_field("error_flag",    32'(want.error_flag),    32'(rsp_ch.error_flag));
            check_field("error_code",    32'(want.error_code),    32'(rsp_ch.error_code));
            check_field("end_of_string", 32'(want.end_of_string), 32'(rsp_ch.end_of_string));
            check_field("string_valid",  32'(want.string_valid),  32'(rsp_ch.string_valid));
            check_field("char_count",    32'(want.char_count),    32'(rsp_ch.char_count));
            if (want.char_done) chars_seen++;
            if (want.error_flag) err_hits[want.error_code]++;
         end
      end
   end

   // watchdog: too long without any handshake on either side
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= 4000) begin
         $display("%0t ns: no progress for %0d cycles", $time, stall_cycles);
         $display("utf8_stream_decoder_validator_core_test: done, errors");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // stimulus sequence
   // ------------------------------------------------------------------
   initial begin
      tx_idle_pct      = 34;
      rx_idle_pct      = 86;
      mismatches       = 0;
      bytes_queued     = 0;
      bytes_sent       = 0;
      strings_sent     = 0;
      rsps_seen        = 0;
      chars_seen       = 0;
      foreach (err_hits[i]) err_hits[i] = 0;
      cont_left        = '0;
      seq_len          = '0;
      acc              = '0;
      err_seen         = 1'b0;
      n_chars          = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // smallest and largest ascii
      str_bytes = '{8'h00, 8'h7F};
      queue_string();
      // two-byte range ends, then the top scalar value
      str_bytes = '{8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
      queue_string();
      // overlong two-byte form
      str_bytes = '{8'hC0, 8'h80};
      queue_string();
      // surrogate
      str_bytes = '{8'hED, 8'hA0, 8'h80};
      queue_string();
      // above 10ffff
      str_bytes = '{8'hF5, 8'h80, 8'h80, 8'h80};
      queue_string();
      // stray continuation as lead, ignored byte, final result without error flag
      str_bytes = '{8'h80, 8'h41};
      queue_string();
      // f8 and ff leads
      str_bytes = '{8'hF8};
      queue_string();
      str_bytes = '{8'hFF};
      queue_string();
      // bad continuation on the final byte
      str_bytes = '{8'hE2, 8'h41};
      queue_string();
      // truncated sequence
      str_bytes = '{8'hE2, 8'h82};
      queue_string();

      // slow receiver
      random_strings(360);
      drain();

      // slow sender
      tx_idle_pct = 86;
      rx_idle_pct = 34;
      random_strings(370);
      drain();

      // both sides at full rate
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      random_strings(370);
      drain();

      // catch any stray response after the last one
      repeat (8) @(posedge clock);

      $display("covered %0d bytes in %0d strings, %0d responses with %0d characters",
               bytes_sent, strings_sent, rsps_seen, chars_seen);
      $display("first errors: lead %0d, continuation %0d, overlong %0d, range %0d, truncated %0d",
               err_hits[ERR_LEAD], err_hits[ERR_CONT], err_hits[ERR_OVERLONG],
               err_hits[ERR_RANGE], err_hits[ERR_TRUNC]);
      if (mismatches == 0 && decoded_q.size() == 0) begin
         $display("utf8_stream_decoder_validator_core_test: done, clean");
      end else begin
         $display("utf8_stream_decoder_validator_core_test: done, errors");
      end
      $finish;
   end

endmodule
